### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the projector checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted
`define IGPP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset
`define IGPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/igpp_pkg.sv
// ----------------------------------------------------------------------------
// igpp_pkg
// Types and constants shared by the grid point projector modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package igpp_pkg;

  // Register stages from input capture to output register
  localparam int NUM_STAGES = 8;

  // Configuration port widths
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Saturation bounds of a signed Q16.8 coordinate
  localparam logic [23:0] SAT_POS = 24'h7F_FFFF;
  localparam logic [23:0] SAT_NEG = 24'h80_0000;

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_ROT    = 4'd0,
    REG_SIN_ROT    = 4'd1,
    REG_ZOOM_SCALE = 4'd2,
    REG_TILT       = 4'd3,
    REG_OFFSET_X   = 4'd4,
    REG_OFFSET_Y   = 4'd5,
    REG_GRID_ROWS  = 4'd6,
    REG_GRID_COLS  = 4'd7
  } cfg_reg_e;

  // Current view configuration
  typedef struct packed {
    logic signed [15:0] cos_rot;
    logic signed [15:0] sin_rot;
    logic        [15:0] zoom_scale;
    logic signed [15:0] tilt;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic        [9:0]  grid_rows;
    logic        [9:0]  grid_cols;
  } cfg_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctl_t;

endpackage

`default_nettype wire

### rtl/core/igpp_cfg_regs.sv
// ----------------------------------------------------------------------------
// igpp_cfg_regs
// View configuration registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module igpp_cfg_regs import igpp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Always able to take a write request
  assign cfg_ready_o = 1'b1;

  // Decode the register index; drop writes beyond the list
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_COS_ROT:    cfg_d.cos_rot    = $signed(cfg_data_i[15:0]);
        REG_SIN_ROT:    cfg_d.sin_rot    = $signed(cfg_data_i[15:0]);
        REG_ZOOM_SCALE: cfg_d.zoom_scale = cfg_data_i[15:0];
        REG_TILT:       cfg_d.tilt       = $signed(cfg_data_i[15:0]);
        REG_OFFSET_X:   cfg_d.offset_x   = $signed(cfg_data_i[23:0]);
        REG_OFFSET_Y:   cfg_d.offset_y   = $signed(cfg_data_i[23:0]);
        REG_GRID_ROWS:  cfg_d.grid_rows  = cfg_data_i[9:0];
        REG_GRID_COLS:  cfg_d.grid_cols  = cfg_data_i[9:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_rot    <= 16'sd16384;
      cfg_q.sin_rot    <= 16'sd0;
      cfg_q.zoom_scale <= 16'd256;
      cfg_q.tilt       <= 16'sd0;
      cfg_q.offset_x   <= 24'sd0;
      cfg_q.offset_y   <= 24'sd0;
      cfg_q.grid_rows  <= 10'd1;
      cfg_q.grid_cols  <= 10'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/igpp_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// igpp_pipe_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// its successor moves on, so bubbles are squeezed out under back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module igpp_pipe_ctrl import igpp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output pipe_ctl_t ctl_o
);

  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] en;

  // Enable chain from the output backwards
  always_comb begin
    en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // Advance valid bits alongside the data
  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign ctl_o.en    = en;

endmodule

`default_nettype wire

### rtl/core/igpp_rotate.sv
// ----------------------------------------------------------------------------
// igpp_rotate
// Stages 0 to 2: centre the grid point, rotate it by cos and sin, and form
// the rotated difference and sum; the elevation term is prepared alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module igpp_rotate import igpp_pkg::*; #(
  parameter int MAX_GRID = 512
) (
  input  wire logic               clk_i,
  input  wire pipe_ctl_t          ctl_i,
  input  wire cfg_t               cfg_i,
  input  wire logic        [8:0]  col_i,
  input  wire logic        [8:0]  row_i,
  input  wire logic signed [15:0] elevation_i,
  output logic signed      [29:0] diff_o,
  output logic signed      [29:0] sum_o,
  output logic signed      [34:0] eprod_o
);

  // Grid sizes are held in 10 bits, so the cap never exceeds 1023
  localparam int          GridCap = (MAX_GRID < 1023) ? MAX_GRID : 1023;
  localparam logic [9:0]  GridLim = 10'(GridCap);

  logic [9:0] cols_n, rows_n;

  logic signed [11:0] cx2_d, cy2_d, cx2_q, cy2_q;
  logic signed [16:0] em6_d, em6_q;

  logic signed [27:0] p_ccx_d, p_scy_d, p_scx_d, p_ccy_d;
  logic signed [27:0] p_ccx_q, p_scy_q, p_scx_q, p_ccy_q;
  logic signed [17:0] kt2;
  logic signed [34:0] ep_d, ep1_q, ep2_q;

  logic signed [28:0] rx, ry;
  logic signed [29:0] diff_d, sum_d, diff_q, sum_q;

  // Clamp grid sizes to one and the cap
  always_comb begin
    cols_n = cfg_i.grid_cols;
    if (cfg_i.grid_cols == 10'd0) begin
      cols_n = 10'd1;
    end else if (cfg_i.grid_cols > GridLim) begin
      cols_n = GridLim;
    end
    rows_n = cfg_i.grid_rows;
    if (cfg_i.grid_rows == 10'd0) begin
      rows_n = 10'd1;
    end else if (cfg_i.grid_rows > GridLim) begin
      rows_n = GridLim;
    end
  end

  // Stage 0: doubled centre offsets and elevation less six
  assign cx2_d = $signed({2'b00, col_i, 1'b0}) - $signed({2'b00, cols_n - 10'd1});
  assign cy2_d = $signed({2'b00, row_i, 1'b0}) - $signed({2'b00, rows_n - 10'd1});
  assign em6_d = $signed({elevation_i[15], elevation_i}) - 17'sd6;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      cx2_q <= cx2_d;
      cy2_q <= cy2_d;
      em6_q <= em6_d;
    end
  end

  // Stage 1: rotation products and elevation times (1 - tilt)
  assign kt2     = 18'sd16384 - $signed({{2{cfg_i.tilt[15]}}, cfg_i.tilt});
  assign p_ccx_d = 28'(cfg_i.cos_rot) * 28'(cx2_q);
  assign p_scy_d = 28'(cfg_i.sin_rot) * 28'(cy2_q);
  assign p_scx_d = 28'(cfg_i.sin_rot) * 28'(cx2_q);
  assign p_ccy_d = 28'(cfg_i.cos_rot) * 28'(cy2_q);
  assign ep_d    = 35'(em6_q) * 35'(kt2);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      p_ccx_q <= p_ccx_d;
      p_scy_q <= p_scy_d;
      p_scx_q <= p_scx_d;
      p_ccy_q <= p_ccy_d;
      ep1_q   <= ep_d;
    end
  end

  // Stage 2: rotated coordinates folded into difference and sum
  assign rx     = 29'(p_ccx_q) - 29'(p_scy_q);
  assign ry     = 29'(p_scx_q) + 29'(p_ccy_q);
  assign diff_d = 30'(rx) - 30'(ry);
  assign sum_d  = 30'(rx) + 30'(ry);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      diff_q <= diff_d;
      sum_q  <= sum_d;
      ep2_q  <= ep1_q;
    end
  end

  assign diff_o  = diff_q;
  assign sum_o   = sum_q;
  assign eprod_o = ep2_q;

endmodule

`default_nettype wire

### rtl/core/igpp_scale.sv
// ----------------------------------------------------------------------------
// igpp_scale
// Stages 3 to 7: apply scale and tilt, round to Q16.8, add the offsets and
// saturate; stage 7 is the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module igpp_scale import igpp_pkg::*; (
  input  wire logic               clk_i,
  input  wire pipe_ctl_t          ctl_i,
  input  wire cfg_t               cfg_i,
  input  wire logic signed [29:0] diff_i,
  input  wire logic signed [29:0] sum_i,
  input  wire logic signed [34:0] eprod_i,
  output logic             [23:0] screen_x_o,
  output logic             [23:0] screen_y_o,
  output logic                    clipped_o
);

  logic signed [16:0] sc_s;
  logic signed [16:0] kt1;

  logic signed [46:0] xd_d, u_d, xd_q, u_q;
  logic signed [34:0] ep3_q;

  logic signed [32:0] xr_d, xr_q;
  logic signed [50:0] w_d, w_q;

  logic        [9:0]  x_top;
  logic               xclip_d, xclip5_q, xclip6_q;
  logic        [23:0] xs_d, xs5_q, xs6_q;
  logic        [41:0] p_lo_d, p_lo_q;
  logic signed [41:0] p_hi_d, p_hi_q;

  logic signed [67:0] yfull_d, yfull_q;

  logic signed [39:0] yr;
  logic        [16:0] y_top;
  logic               yclip;
  logic        [23:0] ys;

  assign sc_s = $signed({1'b0, cfg_i.zoom_scale});
  assign kt1  = 17'sd8192 - $signed({cfg_i.tilt[15], cfg_i.tilt});

  // Stage 3: scale the difference, weight the sum by (0.5 - tilt)
  assign xd_d = 47'(diff_i) * 47'(sc_s);
  assign u_d  = 47'(sum_i) * 47'(kt1);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      xd_q  <= xd_d;
      u_q   <= u_d;
      ep3_q <= eprod_i;
    end
  end

  // Stage 4: round x and add its offset; merge the two y terms
  assign xr_d = 33'((xd_q + 47'sd16384) >>> 15) + 33'(cfg_i.offset_x);
  assign w_d  = 51'(u_q) - (51'(ep3_q) <<< 15);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[4]) begin
      xr_q <= xr_d;
      w_q  <= w_d;
    end
  end

  // Stage 5: saturate x; scale y in two partial products
  assign x_top   = xr_q[32:23];
  assign xclip_d = !((&x_top) || (~|x_top));
  assign xs_d    = xclip_d ? (xr_q[32] ? SAT_NEG : SAT_POS) : xr_q[23:0];
  assign p_lo_d  = 42'(w_q[25:0]) * 42'(cfg_i.zoom_scale);
  assign p_hi_d  = 42'($signed(w_q[50:26])) * 42'(sc_s);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[5]) begin
      xs5_q    <= xs_d;
      xclip5_q <= xclip_d;
      p_lo_q   <= p_lo_d;
      p_hi_q   <= p_hi_d;
    end
  end

  // Stage 6: recombine the partial products with the rounding half
  assign yfull_d = (68'(p_hi_q) <<< 26) + $signed({26'd0, p_lo_q})
                 + 68'sd268435456;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[6]) begin
      yfull_q  <= yfull_d;
      xs6_q    <= xs5_q;
      xclip6_q <= xclip5_q;
    end
  end

  // Stage 7: drop the fraction, add the y offset, saturate and hold
  assign yr    = 40'($signed(yfull_q[67:29])) + 40'(cfg_i.offset_y);
  assign y_top = yr[39:23];
  assign yclip = !((&y_top) || (~|y_top));
  assign ys    = yclip ? (yr[39] ? SAT_NEG : SAT_POS) : yr[23:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[7]) begin
      screen_x_o <= xs6_q;
      screen_y_o <= ys;
      clipped_o  <= xclip6_q | yclip;
    end
  end

endmodule

`default_nettype wire

### rtl/core/iso_grid_point_projector_unit.sv
// ----------------------------------------------------------------------------
// iso_grid_point_projector_unit
// Projects one height-map grid point per request to Q16.8 screen coordinates
// with view rotation, scale, tilt and offsets, saturating on overflow.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tdata: col, row, elevation
//  m_axis    out        m_axis_tvalid/tready    tdata: screen_x, screen_y;
//                                               tuser: clipped
//  cfg       in         cfg_valid_i/ready_o     cfg_index_i, cfg_data_i
//
//  One request a cycle is taken unless an output stall has filled every stage; each
//  result passes through the eight-stage multiply chain (rotate, scale, split y).
//  Reset clears the valid bits and loads the configuration reset values.
//  A stage loads when empty or when its successor moves, so a stall at the
//  output fills empty stages first and loses or repeats nothing.
//  cfg_ready_o is always high; a write takes effect on the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iso_grid_point_projector_unit import igpp_pkg::*; #(
  parameter int MAX_GRID = 512
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input points
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [39:0]           s_axis_tdata,  // col[8:0], row[17:9], elevation[33:18]
  // Projected points
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [47:0]                m_axis_tdata,  // screen_x[23:0], screen_y[47:24]
  output logic [0:0]                 m_axis_tuser,  // clipped[0]
  // Configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t        cfg;
  pipe_ctl_t   ctl;
  logic signed [29:0] diff, sum;
  logic signed [34:0] eprod;
  logic        [23:0] screen_x, screen_y;
  logic               clipped;

  igpp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  igpp_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctl_o       (ctl)
  );

  igpp_rotate #(
    .MAX_GRID (MAX_GRID)
  ) u_rotate (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .cfg_i       (cfg),
    .col_i       (s_axis_tdata[8:0]),
    .row_i       (s_axis_tdata[17:9]),
    .elevation_i ($signed(s_axis_tdata[33:18])),
    .diff_o      (diff),
    .sum_o       (sum),
    .eprod_o     (eprod)
  );

  igpp_scale u_scale (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .cfg_i      (cfg),
    .diff_i     (diff),
    .sum_i      (sum),
    .eprod_i    (eprod),
    .screen_x_o (screen_x),
    .screen_y_o (screen_y),
    .clipped_o  (clipped)
  );

  // Pack the result
  assign m_axis_tdata = {screen_y, screen_x};
  assign m_axis_tuser = clipped;

endmodule

`default_nettype wire

### rtl/core/igpp_checker.sv
// ----------------------------------------------------------------------------
// igpp_checker
// Port-level checks on the projector, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module igpp_checker import igpp_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [47:0]           m_axis_tdata,
  input wire logic [0:0]            m_axis_tuser
);

  // Nothing leaves the pipeline in the cycle after reset is seen
  `IGPP_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !m_axis_tvalid, "result valid after reset")

  // An empty or draining output stage never blocks new requests
  `IGPP_ASSERT(a_ready_free, clk_i, rst_ni, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input stalled with output free")

  // A clipped result carries a saturation bound in one coordinate
  `IGPP_ASSERT(a_clip_bound, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[23:0] == SAT_POS || m_axis_tdata[23:0] == SAT_NEG || m_axis_tdata[47:24] == SAT_POS || m_axis_tdata[47:24] == SAT_NEG), "clip flag without bound")

  // A stalled result holds
  `IGPP_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

endmodule

bind iso_grid_point_projector_unit igpp_checker u_igpp_checker (.*);

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for iso_grid_point_projector_unit: grid points are
// streamed in under several view settings and every projected point is
// checked against a behavioural projection or a typed expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import igpp_pkg::*;

  localparam int GRID_LIMIT      = 512;
  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int QUIET_LIMIT     = 2000;
  localparam int REPORT_LIMIT    = 10;
  localparam int NUM_PHASES      = 3;
  localparam int VIEWS_PER_PHASE = 2;
  localparam int POINTS_PER_VIEW = 250;
  localparam int SEND_IDLE_PCT [NUM_PHASES] = '{8, 65, 0};
  localparam int RECV_IDLE_PCT [NUM_PHASES] = '{65, 8, 0};

  // Projection arithmetic: Q2.14 constants, rounding halves and output bounds
  localparam longint HALF_Q14     = 8192;
  localparam longint ONE_Q14      = 16384;
  localparam longint ELEV_BIAS    = 6;
  localparam longint Y_LIFT       = 32768;
  localparam int     X_SHIFT      = 15;
  localparam int     Y_SHIFT      = 29;
  localparam longint X_HALF       = 64'sd1 <<< (X_SHIFT - 1);
  localparam longint Y_HALF       = 64'sd1 <<< (Y_SHIFT - 1);
  localparam longint COORD_MAX    = 8388607;
  localparam longint COORD_MIN    = -8388608;

  // Indices past the register file; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_FIRST = CFG_IDX_W'(REG_GRID_COLS + 1);
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LAST  = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic [23:0] screen_x;
    logic [23:0] screen_y;
    logic        clipped;
  } proj_t;

  // One row of the directed script: a register write or a point
  typedef struct packed {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] idx;
    logic [23:0]          data;
    logic [8:0]           col;
    logic [8:0]           row;
    logic [15:0]          elev;
    bit                   typed;
    proj_t                res;
  } step_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [39:0]           s_axis_tdata  = '0;  // col[8:0], row[17:9], elevation[33:18]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [47:0]           m_axis_tdata;        // screen_x[23:0], screen_y[47:24]
  logic [0:0]            m_axis_tuser;        // clipped[0]
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  cfg_t   view;
  proj_t  pending_points [$];
  step_t  script [$];
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     mismatch_count = 0;
  int     quiet_cycles = 0;

  iso_grid_point_projector_unit #(
    .MAX_GRID(GRID_LIMIT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Grid size in use: zero counts as one, oversize clamps to the limit
  function automatic longint grid_span(input logic [9:0] n);
    if (n == 0) return 1;
    if (n > GRID_LIMIT) return GRID_LIMIT;
    return longint'(n);
  endfunction

  // Exact projection of one grid point under the current view
  function automatic proj_t project_point(input logic [8:0] col, input logic [8:0] row,
                                          input logic signed [15:0] elev);
    longint c, s, sc, t, cx2, cy2, rx, ry, x, y;
    proj_t  res;
    c   = $signed(view.cos_rot);
    s   = $signed(view.sin_rot);
    sc  = view.zoom_scale;
    t   = $signed(view.tilt);
    cx2 = 2 * longint'(col) - (grid_span(view.grid_cols) - 1);
    cy2 = 2 * longint'(row) - (grid_span(view.grid_rows) - 1);
    rx  = c * cx2 - s * cy2;
    ry  = s * cx2 + c * cy2;
    x   = (((rx - ry) * sc + X_HALF) >>> X_SHIFT) + longint'($signed(view.offset_x));
    y   = (((rx + ry) * sc * (HALF_Q14 - t)
           - (longint'(elev) - ELEV_BIAS) * sc * (ONE_Q14 - t) * Y_LIFT
           + Y_HALF) >>> Y_SHIFT) + longint'($signed(view.offset_y));
    res.clipped = 1'b0;
    if (x > COORD_MAX) begin
      x = COORD_MAX;
      res.clipped = 1'b1;
    end else if (x < COORD_MIN) begin
      x = COORD_MIN;
      res.clipped = 1'b1;
    end
    if (y > COORD_MAX) begin
      y = COORD_MAX;
      res.clipped = 1'b1;
    end else if (y < COORD_MIN) begin
      y = COORD_MIN;
      res.clipped = 1'b1;
    end
    res.screen_x = x[23:0];
    res.screen_y = y[23:0];
    return res;
  endfunction

  // Random register value: mostly plausible, sometimes an extreme; junk above the width
  function automatic logic [23:0] random_reg_value(input cfg_reg_e r);
    logic [23:0] data;
    int          pick;
    data = 24'($urandom);
    pick = $urandom_range(4);
    case (r)
      REG_COS_ROT, REG_SIN_ROT: begin
        if (pick == 0) data[15:0] = 16'h8000;
        else if (pick == 1) data[15:0] = 16'h7FFF;
        else data[15:0] = 16'($urandom_range(32768)) - 16'd16384;
      end
      REG_ZOOM_SCALE: begin
        if (pick == 0) data[15:0] = 16'hFFFF;
        else if (pick == 1) data[15:0] = 16'h0000;
        else data[15:0] = 16'($urandom_range(1024, 16));
      end
      REG_TILT: begin
        if (pick == 0) data[15:0] = 16'h8000;
        else if (pick == 1) data[15:0] = 16'h7FFF;
        else if (pick == 2) data[15:0] = 16'($urandom);
        else data[15:0] = 16'($urandom_range(3000)) - 16'd1500;
      end
      REG_OFFSET_X, REG_OFFSET_Y: begin
        if (pick == 0) data = 24'h800000;
        else if (pick == 1) data = 24'h7FFFFF;
        else if (pick > 2) data = 24'($urandom_range(1 << 18)) - 24'd131072;
      end
      default: begin
        if (pick == 0) data[9:0] = 10'd0;
        else if (pick == 1) data[9:0] = 10'h3FF;
        else if (pick > 2) data[9:0] = 10'($urandom_range(64, 1));
      end
    endcase
    return data;
  endfunction

  function automatic step_t write_step(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    step_t st;
    st          = '0;
    st.is_write = 1'b1;
    st.idx      = idx;
    st.data     = data;
    return st;
  endfunction

  function automatic step_t point_step(input logic [8:0] col, input logic [8:0] row,
                                       input logic [15:0] elev, input bit typed = 1'b0,
                                       input proj_t res = '0);
    step_t st;
    st       = '0;
    st.col   = col;
    st.row   = row;
    st.elev  = elev;
    st.typed = typed;
    st.res   = res;
    return st;
  endfunction

  // Offer one point; entered and left at a falling edge
  task automatic feed_point(input logic [8:0] col, input logic [8:0] row,
                            input logic signed [15:0] elev, input bit typed = 1'b0,
                            input proj_t typed_res = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, elev, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_points.push_back(typed ? typed_res : project_point(col, row, elev));
    @(negedge clk_i);
  endtask

  // Hold off input and wait until every projected point has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk_i);
  endtask

  // Write one register and mirror it in the local view
  task automatic program_register(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_COS_ROT:    view.cos_rot    = data[15:0];
      REG_SIN_ROT:    view.sin_rot    = data[15:0];
      REG_ZOOM_SCALE: view.zoom_scale = data[15:0];
      REG_TILT:       view.tilt       = data[15:0];
      REG_OFFSET_X:   view.offset_x   = data;
      REG_OFFSET_Y:   view.offset_y   = data;
      REG_GRID_ROWS:  view.grid_rows  = data[9:0];
      REG_GRID_COLS:  view.grid_cols  = data[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each projected point with the oldest one outstanding
  always @(posedge clk_i) begin : check_results
    proj_t got;
    proj_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tuser[0]};
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected point x=%h y=%h clip=%b", $realtime,
                   got.screen_x, got.screen_y, got.clipped);
      end else begin
        want = pending_points.pop_front();
        if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
            got.clipped !== want.clipped) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: point mismatch x exp %h got %h, y exp %h got %h, clip exp %b got %b",
                     $realtime, want.screen_x, got.screen_x, want.screen_y, got.screen_y,
                     want.clipped, got.clipped);
        end
      end
    end
  end

  // Abort when no request moves on any channel for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("iso_grid_point_projector_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [8:0]         col;
    logic [8:0]         row;
    logic signed [15:0] elev;

    view = '{cos_rot: 16'sd16384, sin_rot: 16'sd0, zoom_scale: 16'd256, tilt: 16'sd0,
             offset_x: 24'sd0, offset_y: 24'sd0, grid_rows: 10'd1, grid_cols: 10'd1};

    // Reset view: x = (col - row) * 256, y = (col + row) * 128 - (elev - 6) * 256
    script = '{
      point_step(9'd0,   9'd0,   16'sd6,      1'b1, '{24'h000000, 24'h000000, 1'b0}),
      point_step(9'd0,   9'd0,   16'sd0,      1'b1, '{24'h000000, 24'h000600, 1'b0}),
      point_step(9'd511, 9'd0,   16'sd6,      1'b1, '{24'h01FF00, 24'h00FF80, 1'b0}),
      point_step(9'd0,   9'd511, 16'sd6,      1'b1, '{24'hFE0100, 24'h00FF80, 1'b0}),
      point_step(9'd0,   9'd0,   16'sd32767,  1'b1, '{24'h000000, 24'h800700, 1'b0}),
      point_step(9'd0,   9'd0,   -16'sd32768, 1'b1, '{24'h000000, 24'h7FFFFF, 1'b1}),
      point_step(9'd511, 9'd511, -16'sd32768, 1'b1, '{24'h000000, 24'h7FFFFF, 1'b1}),
      // writes past the register file leave the view alone
      write_step(IDX_UNUSED_FIRST, 24'hFFFFFF),
      write_step(IDX_UNUSED_LAST,  24'h123456),
      point_step(9'd511, 9'd0,   16'sd6,      1'b1, '{24'h01FF00, 24'h00FF80, 1'b0}),
      // x driven below the negative bound
      write_step(REG_OFFSET_X, 24'h800000),
      point_step(9'd0,   9'd511, 16'sd6,      1'b1, '{24'h800000, 24'h00FF80, 1'b1}),
      // extreme view; junk above each register width, row count zero, column count oversize
      write_step(REG_COS_ROT,    24'hAB8000),
      write_step(REG_SIN_ROT,    24'h007FFF),
      write_step(REG_ZOOM_SCALE, 24'h5AFFFF),
      write_step(REG_TILT,       24'h008000),
      write_step(REG_OFFSET_Y,   24'h7FFFFF),
      write_step(REG_GRID_ROWS,  24'h000000),
      write_step(REG_GRID_COLS,  24'hFFF3FF),
      point_step(9'd511, 9'd511, 16'sd32767),
      point_step(9'd0,   9'd0,   -16'sd32768),
      point_step(9'd511, 9'd0,   -16'sd1),
      write_step(REG_GRID_ROWS,  24'h000201),
      write_step(REG_GRID_COLS,  24'h000000),
      point_step(9'd256, 9'd255, 16'sd0),
      write_step(REG_TILT,       24'h007FFF),
      write_step(REG_ZOOM_SCALE, 24'h000000),
      point_step(9'd0,   9'd511, 16'sd32767)
    };

    // Reset, then release on a falling edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed script
    send_idle_pct = SEND_IDLE_PCT[0];
    recv_idle_pct = RECV_IDLE_PCT[0];
    foreach (script[i]) begin
      if (script[i].is_write) begin
        settle();
        program_register(script[i].idx, script[i].data);
      end else begin
        feed_point(script[i].col, script[i].row, script[i].elev, script[i].typed,
                   script[i].res);
      end
    end

    // Random views, each followed by a stream of random points
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      send_idle_pct = SEND_IDLE_PCT[phase];
      recv_idle_pct = RECV_IDLE_PCT[phase];
      for (int view_no = 0; view_no < VIEWS_PER_PHASE; view_no++) begin
        settle();
        for (int r = REG_COS_ROT; r <= REG_GRID_COLS; r++)
          program_register(CFG_IDX_W'(r), random_reg_value(cfg_reg_e'(r)));
        if ($urandom_range(1) == 0)
          program_register(CFG_IDX_W'($urandom_range(IDX_UNUSED_LAST, IDX_UNUSED_FIRST)),
                           24'($urandom));
        for (int n = 0; n < POINTS_PER_VIEW; n++) begin
          // Mostly on the grid, sometimes anywhere in the index range
          if ($urandom_range(3) != 0) begin
            col = 9'($urandom_range(int'(grid_span(view.grid_cols)) - 1));
            row = 9'($urandom_range(int'(grid_span(view.grid_rows)) - 1));
          end else begin
            col = 9'($urandom);
            row = 9'($urandom);
          end
          if ($urandom_range(3) != 0) elev = 16'($urandom_range(64)) - 16'd32;
          else elev = 16'($urandom);
          feed_point(col, row, elev);
        end
      end
    end

    // Drain and let the pipeline run dry
    settle();
    repeat (NUM_STAGES + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("iso_grid_point_projector_unit test passed");
    end else begin
      $display("iso_grid_point_projector_unit test failed");
    end
    $finish;
  end

endmodule
